// ===== hw/rtl/spq_pkg.sv =====
// shared constants and types for the sorted priority queue
`default_nettype none

package spq_pkg;

  // storage geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // fixed field widths
  localparam int TAG_W    = 16;
  localparam int PRI_W    = 16;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  // request modes
  localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UPGRADE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd3;

  // response status codes
  localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY      = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL       = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_NOT_RAISED = 3'd4;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_SCAN,
    ST_INS_PUT,
    ST_UPG_SCAN,
    ST_UPG_DROP,
    ST_POP,
    ST_DONE
  } seq_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sorted_priority_queue_decrease_key.sv =====
// sorted priority queue with insert, pop, upgrade and clear
`default_nettype none

// Bounded priority queue of QUEUE_DEPTH (tag, priority) entries kept in
// service order: lower priority value first, older entry first among equals.
// Each transfer on the input channel gives exactly one response transfer.
// A single compare unit walks the slots one per cycle under a small sequencer,
// and in_stall stays high from the accepted request until its response is in
// the output register: clear, pop on an empty queue and insert on a full
// queue go straight to the response; pop removes the front entry; insert
// scans past the held entries at or ahead of the new priority and then opens
// a gap there; upgrade scans to the tag, drops it and reinserts it the same
// way; an upgrade that does not raise stops at the tag, and one whose tag is
// missing scans all held entries. The next request is taken while a
// response still waits on out_stall. No clearing pass is needed after reset.
module sorted_priority_queue_decrease_key
  import spq_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // request channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [MODE_W-1:0]   in_mode,
  input  wire logic [TAG_W-1:0]    in_tag,
  input  wire logic [PRI_W-1:0]    in_priority_req,
  // response channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [STATUS_W-1:0]      out_status,
  output logic [TAG_W-1:0]         out_tag,
  output logic [PRI_W-1:0]         out_priority,
  output logic                     out_is_empty,
  output logic [COUNT_W-1:0]       out_entry_count
);

  // control state
  seq_state_t           state_r, state_nxt;
  logic [CNT_W-1:0]     held_r, held_nxt;
  logic [CNT_W-1:0]     scan_r, scan_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // request and result payload
  logic [TAG_W-1:0]     tag_r;
  logic [PRI_W-1:0]     pri_r;
  logic [STATUS_W-1:0]  status_r, status_nxt;
  logic                 popped_r, popped_nxt;
  logic [TAG_W-1:0]     pop_tag_r;
  logic [PRI_W-1:0]     pop_pri_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [TAG_W-1:0]     out_tag_r;
  logic [PRI_W-1:0]     out_pri_r;
  logic [CNT_W-1:0]     out_count_r;

  // slot storage, index 0 is the front
  logic [TAG_W-1:0]     slot_tag_r [QUEUE_DEPTH];
  logic [PRI_W-1:0]     slot_pri_r [QUEUE_DEPTH];

  // slot update strobes
  logic                 do_put;
  logic                 do_drop;
  logic                 in_xfer;
  logic                 load_out;

  // shared compare unit on the scanned slot
  logic [IDX_W-1:0]     scan_idx;
  logic                 in_range;
  logic                 pri_le;
  logic                 tag_eq;

  assign scan_idx = scan_r[IDX_W-1:0];
  assign in_range = (scan_r < held_r);
  assign pri_le   = (slot_pri_r[scan_idx] <= pri_r);
  assign tag_eq   = (slot_tag_r[scan_idx] == tag_r);

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  // next state and control
  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    scan_nxt      = scan_r;
    status_nxt    = status_r;
    popped_nxt    = popped_r;
    out_valid_nxt = out_valid_r;
    do_put        = 1'b0;
    do_drop       = 1'b0;
    load_out      = 1'b0;

    // response register drains independently
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          scan_nxt   = '0;
          status_nxt = STAT_OK;
          popped_nxt = 1'b0;
          case (in_mode)
            MODE_INSERT: begin
              if (held_r >= CNT_W'(QUEUE_DEPTH)) begin
                status_nxt = STAT_FULL;
                state_nxt  = ST_DONE;
              end else begin
                state_nxt = ST_INS_SCAN;
              end
            end
            MODE_POP: begin
              if (held_r == '0) begin
                status_nxt = STAT_EMPTY;
                state_nxt  = ST_DONE;
              end else begin
                state_nxt = ST_POP;
              end
            end
            MODE_UPGRADE: begin
              state_nxt = ST_UPG_SCAN;
            end
            MODE_CLEAR: begin
              held_nxt  = '0;
              state_nxt = ST_DONE;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      // find the first slot with a less urgent priority
      ST_INS_SCAN: begin
        if (in_range && pri_le) begin
          scan_nxt = scan_r + CNT_W'(1);
        end else begin
          state_nxt = ST_INS_PUT;
        end
      end
      ST_INS_PUT: begin
        do_put    = 1'b1;
        held_nxt  = held_r + CNT_W'(1);
        state_nxt = ST_DONE;
      end
      // find the first slot holding the tag
      ST_UPG_SCAN: begin
        if (!in_range) begin
          status_nxt = STAT_NOT_FOUND;
          state_nxt  = ST_DONE;
        end else if (tag_eq) begin
          if (pri_le) begin
            status_nxt = STAT_NOT_RAISED;
            state_nxt  = ST_DONE;
          end else begin
            state_nxt = ST_UPG_DROP;
          end
        end else begin
          scan_nxt = scan_r + CNT_W'(1);
        end
      end
      ST_UPG_DROP: begin
        do_drop   = 1'b1;
        held_nxt  = held_r - CNT_W'(1);
        scan_nxt  = '0;
        state_nxt = ST_INS_SCAN;
      end
      ST_POP: begin
        do_drop    = 1'b1;
        held_nxt   = held_r - CNT_W'(1);
        popped_nxt = 1'b1;
        state_nxt  = ST_DONE;
      end
      // hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_r      <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
      status_r    <= STAT_OK;
      popped_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
      popped_r    <= popped_nxt;
    end
  end

  // request capture and popped entry
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      tag_r <= in_tag;
      pri_r <= in_priority_req;
    end
    if (state_r == ST_POP) begin
      pop_tag_r <= slot_tag_r[0];
      pop_pri_r <= slot_pri_r[0];
    end
  end

  // slot shifts: open a gap at the scan position or close one there
  always_ff @(posedge clk) begin
    if (do_drop) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        if (CNT_W'(i) >= scan_r) begin
          slot_tag_r[i] <= slot_tag_r[i + 1];
          slot_pri_r[i] <= slot_pri_r[i + 1];
        end
      end
    end
    if (do_put) begin
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
        if (CNT_W'(i) > scan_r) begin
          slot_tag_r[i] <= slot_tag_r[i - 1];
          slot_pri_r[i] <= slot_pri_r[i - 1];
        end
      end
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (CNT_W'(i) == scan_r) begin
          slot_tag_r[i] <= tag_r;
          slot_pri_r[i] <= pri_r;
        end
      end
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= status_r;
      out_count_r  <= held_r;
      if (popped_r) begin
        out_tag_r <= pop_tag_r;
        out_pri_r <= pop_pri_r;
      end else if (held_r != '0) begin
        out_tag_r <= slot_tag_r[0];
        out_pri_r <= slot_pri_r[0];
      end else begin
        out_tag_r <= '0;
        out_pri_r <= '0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_tag         = out_tag_r;
  assign out_priority    = out_pri_r;
  assign out_is_empty    = (out_count_r == '0);
  assign out_entry_count = COUNT_W'(out_count_r);

  // count never passes the depth
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CNT_W'(QUEUE_DEPTH))
    else $error("held count above queue depth");

  // a placement only happens with room left
  a_put_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INS_PUT) |-> (held_r < CNT_W'(QUEUE_DEPTH)))
    else $error("insert into a full queue");

  // scans stay within the held entries
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INS_SCAN || state_r == ST_UPG_SCAN) |-> (scan_r <= held_r))
    else $error("scan position past held entries");

  // a pop drops exactly one entry
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP) |=> (held_r == $past(held_r) - CNT_W'(1)))
    else $error("pop did not remove one entry");

endmodule

`default_nettype wire
